// ===== hw/rtl/wsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_pkg
// Shared types and constants of the windowed scan correspondence block.
// ----------------------------------------------------------------------------
package wsc_pkg;

  localparam int READING_W = 8;
  localparam int RANGE_W   = 16;
  localparam int POS_W     = 17;
  localparam int COUNT_W   = 9;
  localparam int WINDOW_W  = 8;
  localparam int LIMIT_W   = 15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_READING_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_LIMIT = 2'd2;

  localparam logic [COUNT_W-1:0]  RST_READING_COUNT = 9'd255;
  localparam logic [WINDOW_W-1:0] RST_WINDOW_HALF   = 8'd15;
  localparam logic [LIMIT_W-1:0]  RST_OUTLIER_LIMIT = 15'd100;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [RANGE_W-1:0] range_mm;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
  } model_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_CHECK
  } state_t;

endpackage

// ===== hw/rtl/wsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_query_if / wsc_result_if
// Valid/ready channels for scan readings in and correspondences out.
// ----------------------------------------------------------------------------
interface wsc_query_if;
  import wsc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [READING_W-1:0]        reading_index;
  logic signed [RANGE_W-1:0]   range_mm;
  logic signed [POS_W-1:0]     pos_x;
  logic signed [POS_W-1:0]     pos_y;

  modport source (output valid, mode, reading_index, range_mm, pos_x, pos_y, input ready);
  modport sink (input valid, mode, reading_index, range_mm, pos_x, pos_y, output ready);
endinterface

interface wsc_result_if;
  import wsc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [READING_W-1:0] query_index;
  logic                 match_found;
  logic [READING_W-1:0] match_index;

  modport source (output valid, query_index, match_found, match_index, input ready);
  modport sink (input valid, query_index, match_found, match_index, output ready);
endinterface

// ===== hw/rtl/wsc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wsc_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/windowed_scan_correspondence.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_scan_correspondence
// Closest-point search of a query reading over a window of a stored model scan.
//
//   channel   dir  modport  payload
//   query     in   sink     mode, reading_index, range_mm, pos_x, pos_y
//   result    out  source   query_index, match_found, match_index
//   cfg_*     in   -        cfg_we, cfg_index, cfg_data
//
// A model load is written to the RAM when it is accepted. A query reads its
// clipped window (2*window_half+1 entries at most) one model entry per cycle
// from the single RAM read port, followed by a drain through the distance
// pipeline and its compare. A bad query or an empty window skips the scan.
// No new reading is taken until a query is done. A finished result waits in
// the output register; a further query finishes only when it is taken.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module windowed_scan_correspondence #(
  parameter int MAX_READINGS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  wsc_query_if.sink                        query,
  wsc_result_if.source                     result
);
  import wsc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_READINGS);
  localparam int SPAN_W = ((IDX_W > READING_W) ? IDX_W : READING_W) + 1;
  localparam int WRAP_N = 2 ** READING_W;
  localparam int SQ_W   = 2 * POS_W;

  state_t state, state_next;

  logic [COUNT_W-1:0]  reading_count;
  logic [WINDOW_W-1:0] window_half;
  logic [LIMIT_W-1:0]  outlier_limit;

  logic [READING_W-1:0]      q_idx;
  logic signed [RANGE_W-1:0] q_rng;
  logic signed [POS_W-1:0]   q_x;
  logic signed [POS_W-1:0]   q_y;

  logic [SPAN_W-1:0] lo_r, hi_r, j;

  logic              a_vld;
  logic [IDX_W-1:0]  a_idx;
  logic              b_vld;
  logic [IDX_W-1:0]  b_idx;
  logic [RANGE_W-1:0] b_rng;
  logic [POS_W-1:0]  b_ax, b_ay;
  logic              c_vld;
  logic [IDX_W-1:0]  c_idx;
  logic [RANGE_W-1:0] c_rng;
  logic [SQ_W-1:0]   c_sx, c_sy;

  logic               have;
  logic [SQ_W:0]      best_d;
  logic [IDX_W-1:0]   best_idx;
  logic [RANGE_W-1:0] best_rng;

  logic                 out_vld;
  logic [READING_W-1:0] out_qidx;
  logic                 out_found;
  logic [READING_W-1:0] out_midx;

  logic in_xfer, load_we, query_go, rd_en, out_load;

  logic [IDX_W-1:0] wrap_lut [WRAP_N];
  model_entry_t     wr_entry, rd_entry;
  logic [IDX_W-1:0] wr_addr;

  // Load address wraps modulo the table depth.
  for (genvar k = 0; k < WRAP_N; k++) begin : g_wrap
    assign wrap_lut[k] = IDX_W'(k % MAX_READINGS);
  end

  assign in_xfer  = query.valid & query.ready;
  assign load_we  = in_xfer & (query.mode == MODE_LOAD);
  assign query_go = in_xfer & (query.mode == MODE_QUERY);
  assign wr_addr  = wrap_lut[query.reading_index];
  assign wr_entry = '{range_mm: query.range_mm, pos_x: query.pos_x, pos_y: query.pos_y};

  wsc_ram #(
    .WIDTH($bits(model_entry_t)),
    .DEPTH(MAX_READINGS)
  ) u_model (
    .clk   (clk),
    .we    (load_we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (j[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_count <= RST_READING_COUNT;
      window_half   <= RST_WINDOW_HALF;
      outlier_limit <= RST_OUTLIER_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_READING_COUNT: reading_count <= cfg_data[COUNT_W-1:0];
        CFG_WINDOW_HALF:   window_half   <= cfg_data[WINDOW_W-1:0];
        CFG_OUTLIER_LIMIT: outlier_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Window bounds, clipped to the scan.
  logic [SPAN_W-1:0]    cnt_ext, cnt_n, last, hi_w, lo_w;
  logic [READING_W-1:0] lo8;
  logic                 win_empty, q_bad;

  always_comb begin
    cnt_ext = SPAN_W'(reading_count);
    if (cnt_ext == '0) begin
      cnt_n = SPAN_W'(1);
    end else if (cnt_ext > SPAN_W'(MAX_READINGS)) begin
      cnt_n = SPAN_W'(MAX_READINGS);
    end else begin
      cnt_n = cnt_ext;
    end
    last = cnt_n - SPAN_W'(1);
    lo8  = (q_idx > window_half) ? (q_idx - window_half) : '0;
    lo_w = SPAN_W'(lo8);
    hi_w = SPAN_W'({1'b0, q_idx} + {1'b0, window_half});
    if (hi_w > last) begin
      hi_w = last;
    end
    win_empty = lo_w > hi_w;
    q_bad     = q_rng[RANGE_W-1];
  end

  // Range check of the winner.
  logic signed [RANGE_W:0] rdiff;
  logic [RANGE_W-1:0]      adiff;
  logic                    found;

  always_comb begin
    rdiff = {q_rng[RANGE_W-1], q_rng} - {best_rng[RANGE_W-1], best_rng};
    adiff = rdiff[RANGE_W] ? RANGE_W'(-rdiff) : rdiff[RANGE_W-1:0];
    found = have & (adiff < RANGE_W'(outlier_limit));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (query_go) state_next = ST_SETUP;
      ST_SETUP: state_next = (q_bad || win_empty) ? ST_CHECK : ST_SCAN;
      ST_SCAN:  if (j == hi_r) state_next = ST_DRAIN;
      ST_DRAIN: if (!a_vld && !b_vld && !c_vld) state_next = ST_CHECK;
      ST_CHECK: if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    query.ready = (state == ST_IDLE);
    rd_en       = (state == ST_SCAN);
    out_load    = (state == ST_CHECK) && (!out_vld || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      q_idx <= query.reading_index;
      q_rng <= query.range_mm;
      q_x   <= query.pos_x;
      q_y   <= query.pos_y;
    end
    if (state == ST_SETUP) begin
      lo_r <= lo_w;
      hi_r <= hi_w;
      j    <= lo_w;
    end else if (rd_en) begin
      j <= j + SPAN_W'(1);
    end
  end

  // Distance pipeline: difference, square, sum and compare.
  logic signed [POS_W:0] dx, dy;

  always_comb begin
    dx = {q_x[POS_W-1], q_x} - {rd_entry.pos_x[POS_W-1], rd_entry.pos_x};
    dy = {q_y[POS_W-1], q_y} - {rd_entry.pos_y[POS_W-1], rd_entry.pos_y};
  end

  always_ff @(posedge clk) begin
    a_idx <= j[IDX_W-1:0];
    b_idx <= a_idx;
    b_rng <= rd_entry.range_mm;
    b_ax  <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    b_ay  <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    c_idx <= b_idx;
    c_rng <= b_rng;
    c_sx  <= b_ax * b_ax;
    c_sy  <= b_ay * b_ay;
  end

  logic [SQ_W:0] sq_sum;
  assign sq_sum = {1'b0, c_sx} + {1'b0, c_sy};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      have  <= 1'b0;
    end else begin
      a_vld <= rd_en;
      b_vld <= a_vld & ~rd_entry.range_mm[RANGE_W-1];
      c_vld <= b_vld;
      if (state == ST_SETUP) begin
        have <= 1'b0;
      end else if (c_vld && (!have || sq_sum < best_d)) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_vld && (!have || sq_sum < best_d)) begin
      best_d   <= sq_sum;
      best_idx <= c_idx;
      best_rng <= c_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_qidx  <= q_idx;
      out_found <= found;
      out_midx  <= found ? READING_W'(best_idx) : '0;
    end
  end

  assign result.valid       = out_vld;
  assign result.query_index = out_qidx;
  assign result.match_found = out_found;
  assign result.match_index = out_midx;

`ifndef SYNTHESIS
  a_read_from_scan: assert property (@(posedge clk) disable iff (rst)
    a_vld |-> $past(state) == ST_SCAN)
    else $error("read data valid without a scan cycle");

  a_drained_at_check: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> !a_vld && !b_vld && !c_vld)
    else $error("distance pipeline busy at range check");

  a_best_in_window: assert property (@(posedge clk) disable iff (rst)
    have |-> (SPAN_W'(best_idx) >= lo_r) && (SPAN_W'(best_idx) <= hi_r))
    else $error("best index outside search window");

  a_result_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == ST_CHECK)
    else $error("result raised outside range check");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the windowed scan correspondence block.
//
// Loads model readings and sends data queries over the valid/ready query
// channel, and compares every correspondence that comes back with a pinned
// result or one predicted here from a mirrored model table and register set.
// A short directed table covers field extremes, bad readings, ties, the
// outlier edge and empty windows. Random phases then walk through several
// register settings and idling patterns, including one long result stall.
// ----------------------------------------------------------------------------
module tb_top;
  import wsc_pkg::*;

  localparam int NUM_PHASES   = 7;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int PH_COUNT  [NUM_PHASES] = '{255, 256, 1, 0, 511, 64, 200};
  localparam int PH_WINDOW [NUM_PHASES] = '{15, 3, 255, 0, 255, 7, 1};
  localparam int PH_LIMIT  [NUM_PHASES] = '{100, 32767, 1, 0, 500, 2000, 300};
  localparam int PH_ITEMS  [NUM_PHASES] = '{200, 180, 120, 100, 25, 180, 130};
  localparam int SEND_IDLE [4]          = '{0, 71, 0, 8};
  localparam int RECV_STALL[4]          = '{0, 0, 71, 8};

  typedef struct packed {
    logic [READING_W-1:0] query_index;
    logic                 match_found;
    logic [READING_W-1:0] match_index;
  } corr_t;

  typedef struct {
    logic                      mode;
    logic [READING_W-1:0]      idx;
    logic signed [RANGE_W-1:0] rng;
    logic signed [POS_W-1:0]   px;
    logic signed [POS_W-1:0]   py;
    bit                        pinned;
    corr_t                     pinned_res;
  } reading_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wsc_query_if  query_ch ();
  wsc_result_if result_ch ();

  windowed_scan_correspondence u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .query     (query_ch),
    .result    (result_ch)
  );

  model_entry_t         scan_model [256];
  bit                   entry_loaded [256];
  logic [COUNT_W-1:0]   scan_len  = RST_READING_COUNT;
  logic [WINDOW_W-1:0]  half_win  = RST_WINDOW_HALF;
  logic [LIMIT_W-1:0]   range_tol = RST_OUTLIER_LIMIT;

  corr_t pending_matches [$];
  int    mismatch_count = 0;
  int    loads_sent     = 0;
  int    queries_sent   = 0;
  int    matches_seen   = 0;
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  int    hold_req       = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void scan_window(input logic [READING_W-1:0] idx,
                                      output int lo, output int hi);
    int n;
    n = int'(scan_len);
    if (n == 0) n = 1;
    if (n > 256) n = 256;
    lo = (int'(idx) > int'(half_win)) ? int'(idx) - int'(half_win) : 0;
    hi = int'(idx) + int'(half_win);
    if (hi > n - 1) hi = n - 1;
  endfunction

  function automatic corr_t predict_match(reading_t rd);
    corr_t   res;
    int      lo;
    int      hi;
    int      best;
    int      diff;
    bit      have;
    longint  dx;
    longint  dy;
    longint  d;
    longint  best_d;
    res.query_index = rd.idx;
    res.match_found = 1'b0;
    res.match_index = '0;
    have   = 1'b0;
    best   = 0;
    best_d = 0;
    if (rd.rng >= 0) begin
      scan_window(rd.idx, lo, hi);
      for (int j = lo; j <= hi; j++) begin
        if (scan_model[j].range_mm < 0) continue;
        dx = longint'(rd.px) - longint'(scan_model[j].pos_x);
        dy = longint'(rd.py) - longint'(scan_model[j].pos_y);
        d  = dx * dx + dy * dy;
        if (!have || d < best_d) begin
          have   = 1'b1;
          best_d = d;
          best   = j;
        end
      end
      if (have) begin
        diff = int'(rd.rng) - int'(scan_model[best].range_mm);
        if (diff < 0) diff = -diff;
        if (diff < int'(range_tol)) begin
          res.match_found = 1'b1;
          res.match_index = READING_W'(best);
        end
      end
    end
    return res;
  endfunction

  function automatic reading_t row(logic mode, int idx, int rng, int px, int py,
                                   bit pin = 1'b0, bit found = 1'b0, int match = 0);
    reading_t rd;
    rd.mode   = mode;
    rd.idx    = READING_W'(idx);
    rd.rng    = RANGE_W'(rng);
    rd.px     = POS_W'(px);
    rd.py     = POS_W'(py);
    rd.pinned = pin;
    rd.pinned_res.query_index = READING_W'(idx);
    rd.pinned_res.match_found = found;
    rd.pinned_res.match_index = READING_W'(match);
    return rd;
  endfunction

  function automatic reading_t random_model(int idx);
    reading_t rd;
    rd = row(MODE_LOAD, idx, 0, 0, 0);
    case ($urandom_range(9))
      0: rd.rng = RANGE_W'(-int'($urandom_range(32768, 1)));
      1: rd.rng = RANGE_W'($urandom);
      default: rd.rng = RANGE_W'($urandom_range(5000));
    endcase
    if ($urandom_range(3) == 0) begin
      rd.px = POS_W'($urandom);
      rd.py = POS_W'($urandom);
    end else begin
      rd.px = POS_W'(int'($urandom_range(4000)) - 2000);
      rd.py = POS_W'(int'($urandom_range(4000)) - 2000);
    end
    // copy a neighbor's position now and then to force distance ties
    if (entry_loaded[idx ^ 1] && $urandom_range(7) == 0) begin
      rd.px = scan_model[idx ^ 1].pos_x;
      rd.py = scan_model[idx ^ 1].pos_y;
    end
    return rd;
  endfunction

  function automatic reading_t make_query(int idx, int lo, int hi);
    reading_t rd;
    int       j;
    int       tol;
    int       r;
    int       jitter;
    rd = row(MODE_QUERY, idx, 0, 0, 0);
    if (lo <= hi && $urandom_range(99) < 65) begin
      j      = $urandom_range(hi, lo);
      tol    = (range_tol == 0) ? 1 : int'(range_tol);
      r      = int'(scan_model[j].range_mm) + int'($urandom_range(2 * tol)) - tol;
      jitter = ($urandom_range(3) == 0) ? 0 : 50;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      rd.rng = RANGE_W'(r);
      rd.px  = POS_W'(int'(scan_model[j].pos_x) + int'($urandom_range(2 * jitter)) - jitter);
      rd.py  = POS_W'(int'(scan_model[j].pos_y) + int'($urandom_range(2 * jitter)) - jitter);
    end else begin
      rd.rng = RANGE_W'($urandom);
      rd.px  = POS_W'($urandom);
      rd.py  = POS_W'($urandom);
    end
    return rd;
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_READING_COUNT: scan_len  = data[COUNT_W-1:0];
      CFG_WINDOW_HALF:   half_win  = data[WINDOW_W-1:0];
      CFG_OUTLIER_LIMIT: range_tol = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_reading(input reading_t rd);
    while ($urandom_range(99) < send_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(negedge clk);
    end
    query_ch.valid         <= 1'b1;
    query_ch.mode          <= rd.mode;
    query_ch.reading_index <= rd.idx;
    query_ch.range_mm      <= rd.rng;
    query_ch.pos_x         <= rd.px;
    query_ch.pos_y         <= rd.py;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
    if (rd.mode == MODE_LOAD) begin
      scan_model[rd.idx]   = '{range_mm: rd.rng, pos_x: rd.px, pos_y: rd.py};
      entry_loaded[rd.idx] = 1'b1;
      loads_sent++;
    end else begin
      pending_matches.push_back(rd.pinned ? rd.pinned_res : predict_match(rd));
      queries_sent++;
    end
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    corr_t got;
    corr_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.query_index, result_ch.match_found, result_ch.match_index};
      if (got.match_found) matches_seen++;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected transfer: got idx %0d found %0d match %0d",
                 $time, got.query_index, got.match_found, got.match_index);
        mismatch_count++;
      end else begin
        want = pending_matches.pop_front();
        if (got.query_index !== want.query_index || got.match_found !== want.match_found ||
            got.match_index !== want.match_index) begin
          $display("%0t: mismatch: expected idx %0d found %0d match %0d, got idx %0d found %0d match %0d",
                   $time, want.query_index, want.match_found, want.match_index,
                   got.query_index, got.match_found, got.match_index);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : result_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    reading_t directed_rows [$];
    int       sent;
    int       n;
    int       qidx;
    int       lo;
    int       hi;

    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    query_ch.valid         = 1'b0;
    query_ch.mode          = MODE_LOAD;
    query_ch.reading_index = '0;
    query_ch.range_mm      = '0;
    query_ch.pos_x         = '0;
    query_ch.pos_y         = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reading count of eight, window of two, outlier limit left at reset
    write_register(CFG_READING_COUNT, 15'd8);
    write_register(CFG_WINDOW_HALF, 15'd2);
    directed_rows.push_back(row(MODE_LOAD,    0,   1000,      0,      0));
    directed_rows.push_back(row(MODE_LOAD,    1,   1050,    100,      0));
    directed_rows.push_back(row(MODE_LOAD,    2,     -1,    200,      0));
    directed_rows.push_back(row(MODE_LOAD,    3,  32767,  65535,  65535));
    directed_rows.push_back(row(MODE_LOAD,    4,      0, -65536, -65536));
    directed_rows.push_back(row(MODE_LOAD,    5,    500,    300,      0));
    directed_rows.push_back(row(MODE_LOAD,    6,    500,    300,      0));
    directed_rows.push_back(row(MODE_LOAD,    7, -32768,      0,      0));
    directed_rows.push_back(row(MODE_LOAD,  255,      7,     -1,     -1));
    directed_rows.push_back(row(MODE_QUERY,   0,   1000,      0,      0, 1, 1, 0));
    directed_rows.push_back(row(MODE_QUERY,   1,   1099,    100,      0, 1, 1, 1));
    directed_rows.push_back(row(MODE_QUERY,   1,   1150,    100,      0, 1, 0, 0));
    directed_rows.push_back(row(MODE_QUERY,   1,     -1,    100,      0, 1, 0, 0));
    directed_rows.push_back(row(MODE_QUERY,   2, -32768,  65535, -65536, 1, 0, 0));
    directed_rows.push_back(row(MODE_QUERY,   7,    500,    300,      0, 1, 1, 5));
    directed_rows.push_back(row(MODE_QUERY,   3,  32767,  65535,  65535, 1, 1, 3));
    directed_rows.push_back(row(MODE_QUERY,   4,      0, -65536, -65536, 1, 1, 4));
    directed_rows.push_back(row(MODE_QUERY, 200,     10,      5,      5, 1, 0, 0));
    directed_rows.push_back(row(MODE_QUERY, 255,  32767,  65535,  65535, 1, 0, 0));
    directed_rows.push_back(row(MODE_QUERY,   2,    250,    150,      0));
    directed_rows.push_back(row(MODE_QUERY,   6,    450,     -3,     77));
    directed_rows.push_back(row(MODE_LOAD,    6,     -7,    300,      0));
    directed_rows.push_back(row(MODE_LOAD,    5,   -100,    300,      0));
    directed_rows.push_back(row(MODE_QUERY,   7,    500,    300,      0, 1, 0, 0));
    directed_rows.push_back(row(MODE_QUERY,   6,      0, -65536, -65536, 1, 1, 4));
    foreach (directed_rows[i]) send_reading(directed_rows[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      query_ch.valid <= 1'b0;
      while (pending_matches.size() != 0) @(negedge clk);
      repeat (10) @(negedge clk);
      write_register(CFG_READING_COUNT, CFG_DATA_W'(PH_COUNT[p]));
      write_register(CFG_WINDOW_HALF, CFG_DATA_W'(PH_WINDOW[p]));
      write_register(CFG_OUTLIER_LIMIT, CFG_DATA_W'(PH_LIMIT[p]));
      if (p == 3) write_register(CFG_UNUSED, '1);
      send_idle_pct  = SEND_IDLE[p % 4];
      recv_stall_pct = RECV_STALL[p % 4];
      // hold results off while queries keep coming, so the input backs up
      if (p == 0) hold_req = 1;
      n = int'(scan_len);
      if (n == 0) n = 1;
      if (n > 256) n = 256;
      sent = 0;
      while (sent < PH_ITEMS[p]) begin
        if ($urandom_range(99) < 35) begin
          qidx = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(n - 1);
          send_reading(random_model(qidx));
          sent++;
        end else begin
          qidx = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(n - 1);
          scan_window(READING_W'(qidx), lo, hi);
          for (int j = lo; j <= hi; j++) begin
            if (!entry_loaded[j]) begin
              send_reading(random_model(j));
              sent++;
            end
          end
          send_reading(make_query(qidx, lo, hi));
          sent++;
        end
      end
    end

    query_ch.valid <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d model loads and %0d queries across %0d register settings",
             loads_sent, queries_sent, NUM_PHASES + 1);
    $display("%0d queries found a correspondence, %0d found none",
             matches_seen, queries_sent - matches_seen);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wsc_pkg.sv
hw/rtl/wsc_if.sv
hw/rtl/wsc_ram.sv
hw/rtl/windowed_scan_correspondence.sv
verif/tb_top.sv
